// ===== src/rab_pkg.sv =====
// rab_pkg: shared types and constants for the radio air-time budget block.
// Holds the transaction payload structs, register indexes, FSM states and divider request.
// No dependencies.
package rab_pkg;

    // transaction payloads
    typedef struct packed {
        logic        opcode;
        logic [7:0]  payload_len;
        logic [31:0] elapsed_ms;
    } s_item_t;

    typedef struct packed {
        logic [31:0] packet_airtime_us;
        logic [31:0] budget_us;
        logic [31:0] load_ratio;
    } m_item_t;

    // opcodes
    localparam logic OP_TX    = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 19;
    localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SF        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CR        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FSK       = 3'd4;

    // reset values
    localparam logic [18:0] RST_BANDWIDTH = 19'd125000;
    localparam logic [3:0]  RST_SF        = 4'd7;
    localparam logic [3:0]  RST_CR        = 4'd5;
    localparam logic [7:0]  RST_PREAMBLE  = 8'd8;
    localparam logic        RST_FSK       = 1'b0;

    // spreading factor limits
    localparam logic [3:0] SF_MIN = 4'd6;
    localparam logic [3:0] SF_MAX = 4'd12;

    // divider geometry: numerator is left aligned, divisor up to 21 bits
    localparam int unsigned DIV_NUM_W  = 48;
    localparam int unsigned DIV_DEN_W  = 21;
    localparam int unsigned DIV_STEP_W = 6;

    localparam logic [DIV_STEP_W-1:0] STEPS_GRP  = 6'd12;
    localparam logic [DIV_STEP_W-1:0] STEPS_AIR  = 6'd45;

    // fixed arithmetic constants (quarter symbols, us, allowance)
    localparam logic [12:0] HDR_QUARTERS     = 13'd49;   // 4.25 preamble tail + 8 header symbols
    localparam logic [19:0] US_PER_S         = 20'd1000000;
    localparam logic [20:0] ALLOWANCE_US     = 21'd1800000;
    localparam logic [31:0] BUDGET_MAX       = 32'hFFFF_FFFF;

    // load ratio: budget * 2^16 / 1800000 = budget * 1024 / 28125, taken as
    // (budget * ceil(2^57 / 28125)) >> 47, exact over the full 32-bit budget
    localparam logic [42:0] LOAD_RECIP    = 43'd5124095576031;
    localparam logic [21:0] LOAD_RECIP_LO = LOAD_RECIP[21:0];
    localparam logic [20:0] LOAD_RECIP_HI = LOAD_RECIP[42:22];

    typedef struct packed {
        logic                  start;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
        logic [DIV_STEP_W-1:0] steps;
    } div_req_t;

    // effective configuration after clamping
    typedef struct packed {
        logic [20:0] bw_x4;   // 4 * bandwidth, zero taken as 1 Hz
        logic [3:0]  sf;      // clamped to 6..12
        logic [5:0]  sf_x4;
        logic [3:0]  cr;
        logic [7:0]  pre;
        logic        fsk;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRP_GO,
        ST_GRP_WAIT,
        ST_QUART,
        ST_MUL,
        ST_AIR_GO,
        ST_AIR_WAIT,
        ST_ACCUM,
        ST_DECAY,
        ST_LOAD_MUL,
        ST_LOAD_SUM,
        ST_OUT
    } rab_state_t;

endpackage

// ===== src/rab_cfg.sv =====
// rab_cfg: configuration register file with clamping of the working values.
// Depends on rab_pkg.
module rab_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rab_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rab_pkg::cfg_t                  cfg
);
    import rab_pkg::*;

    logic [18:0] bw_reg;
    logic [3:0]  sf_reg;
    logic [3:0]  cr_reg;
    logic [7:0]  pre_reg;
    logic        fsk_reg;
    logic [3:0]  sf_eff;
    logic [18:0] bw_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_reg  <= RST_BANDWIDTH;
            sf_reg  <= RST_SF;
            cr_reg  <= RST_CR;
            pre_reg <= RST_PREAMBLE;
            fsk_reg <= RST_FSK;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BANDWIDTH: bw_reg  <= cfg_wdata;
                REG_SF:        sf_reg  <= cfg_wdata[3:0];
                REG_CR:        cr_reg  <= cfg_wdata[3:0];
                REG_PREAMBLE:  pre_reg <= cfg_wdata[7:0];
                REG_FSK:       fsk_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (sf_reg < SF_MIN) sf_eff = SF_MIN;
        else if (sf_reg > SF_MAX)     sf_eff = SF_MAX;
        else                          sf_eff = sf_reg;
        bw_eff = (bw_reg == 19'd0) ? 19'd1 : bw_reg;
    end

    assign cfg.bw_x4 = {bw_eff, 2'b00};
    assign cfg.sf    = sf_eff;
    assign cfg.sf_x4 = {sf_eff, 2'b00};
    assign cfg.cr    = cr_reg;
    assign cfg.pre   = pre_reg;
    assign cfg.fsk   = fsk_reg;

endmodule

// ===== src/rab_div.sv =====
// rab_div: shared restoring divider, one quotient bit per cycle.
// Numerator arrives left aligned; the step count sets how many bits are used.
// Depends on rab_pkg.
module rab_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rab_pkg::div_req_t             req,
    output logic [rab_pkg::DIV_NUM_W-1:0] quo,
    output logic                          done
);
    import rab_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0]  num_reg;
    logic [DIV_DEN_W-1:0]  den_reg;
    logic [DIV_DEN_W-1:0]  rem_reg;
    logic [DIV_NUM_W-1:0]  quo_reg;
    logic [DIV_DEN_W:0]    trial;
    logic [DIV_DEN_W:0]    diff;
    logic                  fits;

    always_comb begin
        trial = {rem_reg, num_reg[DIV_NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
                num_reg  <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
                rem_reg <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("divider did not start");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg < den_reg))
        else $error("partial remainder not below divisor");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("done raised while still iterating");

endmodule

// ===== src/radio_airtime_budget.sv =====
// radio_airtime_budget: transmit air-time budget keeper, top level.
// Sequencer and datapath around one shared serial divider.
// Depends on rab_pkg, rab_cfg, rab_div.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------------
//  s_      | in  | s_valid / s_ready     | s_data  (opcode, payload_len, elapsed_ms)
//  m_      | out | m_valid / m_ready     | m_data  (packet_airtime_us, budget_us, load_ratio)
//  cfg_    | in  | cfg_wr_en, no wait    | cfg_index, cfg_wdata
//
// Sequencing: one transaction at a time. A transmit makes two divider runs, of 12 and 45
// steps, each with a start and a wait state; a query decays the budget instead, and an FSK
// transmit skips the divider. The serial divider, one quotient bit per cycle, sets the
// transmit time; the load ratio is a reciprocal product.
// Reset: synchronous, active low; clears config to defaults, budget to zero, no result held.
// Stalls: the result sits in an output register; the sequencer waits at the end only if
// the previous result has not been taken, and s_ready is high only while idle.
module radio_airtime_budget (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input transactions
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rab_pkg::s_item_t               s_data,
    // result transactions
    output logic                           m_valid,
    input  logic                           m_ready,
    output rab_pkg::m_item_t               m_data,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [rab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rab_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rab_pkg::*;

    cfg_t                 cfg;
    div_req_t             div_req;
    logic [DIV_NUM_W-1:0] div_quo;
    logic                 div_done;

    rab_state_t state_reg, state_next;
    s_item_t    item_reg, item_next;
    logic       pos_reg, pos_next;          // payload term positive
    logic [10:0] syms_reg, syms_next;       // payload symbols
    logic [12:0] quart_reg, quart_next;     // packet length in quarter symbols
    logic [32:0] prod_reg, prod_next;       // quarters * 1e6
    logic [31:0] pkt_reg, pkt_next;
    logic [31:0] budget_reg, budget_next;
    logic [31:0] load_reg, load_next;
    logic [53:0] recip_lo_reg, recip_lo_next;   // budget * low reciprocal bits
    logic [52:0] recip_hi_reg, recip_hi_next;   // budget * high reciprocal bits
    m_item_t    m_data_reg, m_data_next;
    logic       m_valid_reg, m_valid_next;

    logic        s_fire;
    logic        out_free;
    logic [11:0] grp_sum;                   // 8*len + 24
    logic [44:0] air_num;                   // quarters * 1e6 * 2^sf
    logic [35:0] decay;                     // elapsed_ms * 10
    logic [32:0] acc_sum;
    logic [74:0] load_sum;                  // budget * reciprocal

    rab_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rab_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .quo     (div_quo),
        .done    (div_done)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    priority if (s_data.opcode == OP_QUERY) state_next = ST_DECAY;
                    else if (cfg.fsk)                       state_next = ST_LOAD_MUL;
                    else                                    state_next = ST_GRP_GO;
                end
            end
            ST_GRP_GO:    state_next = ST_GRP_WAIT;
            ST_GRP_WAIT:  if (div_done) state_next = ST_QUART;
            ST_QUART:     state_next = ST_MUL;
            ST_MUL:       state_next = ST_AIR_GO;
            ST_AIR_GO:    state_next = ST_AIR_WAIT;
            ST_AIR_WAIT:  if (div_done) state_next = ST_ACCUM;
            ST_ACCUM:     state_next = ST_LOAD_MUL;
            ST_DECAY:     state_next = ST_LOAD_MUL;
            ST_LOAD_MUL:  state_next = ST_LOAD_SUM;
            ST_LOAD_SUM:  state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // shared arithmetic terms
    always_comb begin
        grp_sum  = {1'b0, item_reg.payload_len, 3'b000} + 12'd24;
        air_num  = 45'(prod_reg) << cfg.sf;
        decay    = {1'b0, item_reg.elapsed_ms, 3'b000} + {3'b000, item_reg.elapsed_ms, 1'b0};
        acc_sum  = {1'b0, budget_reg} + {1'b0, pkt_reg};
        load_sum = {recip_hi_reg, 22'd0} + {21'd0, recip_lo_reg};
    end

    // outputs and datapath
    always_comb begin
        div_req       = '0;
        item_next     = item_reg;
        pos_next      = pos_reg;
        syms_next     = syms_reg;
        quart_next    = quart_reg;
        prod_next     = prod_reg;
        pkt_next      = pkt_reg;
        budget_next   = budget_reg;
        load_next     = load_reg;
        recip_lo_next = recip_lo_reg;
        recip_hi_next = recip_hi_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    item_next = s_data;
                    pkt_next  = '0;
                end
            end
            ST_GRP_GO: begin
                // ceil((8len - 4sf + 24) / 4sf) as floor((8len + 23) / 4sf)
                pos_next      = (grp_sum > {6'd0, cfg.sf_x4});
                div_req.start = 1'b1;
                div_req.num   = {grp_sum - 12'd1, 36'd0};
                div_req.den   = {15'd0, cfg.sf_x4};
                div_req.steps = STEPS_GRP;
            end
            ST_GRP_WAIT: begin
                if (div_done) begin
                    syms_next = pos_reg ? (div_quo[6:0] * cfg.cr) : 11'd0;
                end
            end
            ST_QUART: begin
                quart_next = {3'b000, cfg.pre, 2'b00} + HDR_QUARTERS + {syms_reg, 2'b00};
            end
            ST_MUL: begin
                prod_next = quart_reg * US_PER_S;
            end
            ST_AIR_GO: begin
                div_req.start = 1'b1;
                div_req.num   = {air_num, 3'b000};
                div_req.den   = cfg.bw_x4;
                div_req.steps = STEPS_AIR;
            end
            ST_AIR_WAIT: begin
                if (div_done) begin
                    pkt_next = (div_quo[47:32] != 16'd0) ? BUDGET_MAX : div_quo[31:0];
                end
            end
            ST_ACCUM: begin
                budget_next = acc_sum[32] ? BUDGET_MAX : acc_sum[31:0];
            end
            ST_DECAY: begin
                budget_next = ({4'd0, budget_reg} > decay) ? (budget_reg - decay[31:0]) : '0;
            end
            ST_LOAD_MUL: begin
                // two partial products of the 43-bit reciprocal
                recip_lo_next = budget_reg * LOAD_RECIP_LO;
                recip_hi_next = budget_reg * LOAD_RECIP_HI;
            end
            ST_LOAD_SUM: begin
                load_next = {4'd0, load_sum[74:47]};
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_next.packet_airtime_us = pkt_reg;
                    m_data_next.budget_us         = budget_reg;
                    m_data_next.load_ratio        = load_reg;
                    m_valid_next                  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            budget_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            budget_reg  <= budget_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg     <= item_next;
        pos_reg      <= pos_next;
        syms_reg     <= syms_next;
        quart_reg    <= quart_next;
        prod_reg     <= prod_next;
        pkt_reg      <= pkt_next;
        load_reg     <= load_next;
        recip_lo_reg <= recip_lo_next;
        recip_hi_reg <= recip_hi_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg != ST_IDLE))
        else $error("accepted transaction left the sequencer idle");

    a_decay_no_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECAY) |=> (budget_reg <= $past(budget_reg)))
        else $error("query raised the budget");

    a_accum_no_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACCUM) |=> (budget_reg >= $past(budget_reg)))
        else $error("transmit lowered the budget");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_GRP_WAIT || state_reg == ST_AIR_WAIT))
        else $error("divider finished outside a wait state");

endmodule
